// File: src/lapef_pkg.sv
// Shared types and constants for the 3x3 Laplacian edge filter.
// Holds the beat payload structs, register indexes and reset values; no dependencies.
package lapef_pkg;

   localparam int PIX_W         = 8;
   localparam int MODE_W        = 1;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;
   localparam int CSR_DATA_W    = 13;
   localparam int CSR_IDX_W     = 2;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int WIDTH_RESET    = 1024;
   localparam int HEIGHT_RESET   = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_CENTER_POS = 1'b0;
   localparam logic [MODE_W-1:0] MODE_CENTER_NEG = 1'b1;

   localparam int PIX_MAX = 255;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             flush;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             row_end;
      logic             frame_end;
   } rsp_type;

endpackage

// File: src/laplacian_edge_filter_3x3.sv
// Top level of the streaming 3x3 four-neighbor Laplacian edge filter.
// Holds the two line stores, the window registers and the result register; uses lapef_pkg.
//
//   Port group | Direction | Handshake             | Beat payload
//   req_       | in        | req_valid / req_ready | lapef_pkg::req_type
//   rsp_       | out       | rsp_valid / rsp_ready | lapef_pkg::rsp_type
//   csr_       | in        | csr_we                | csr_index, csr_wdata
//
// One beat is taken every cycle while req_ready is high; a result appears in the cycle after its input beat.
// The line store read ports are registered and prefetch the next column on each beat.
// Reset is synchronous; the line stores hold no reset value and need no clearing pass.
// req_ready drops only while the result register is full and rsp_ready is low.
module laplacian_edge_filter_3x3 #(
   parameter int MAX_WIDTH  = lapef_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lapef_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lapef_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lapef_pkg::rsp_type                  rsp_data,
   input  logic                                csr_we,
   input  logic [lapef_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lapef_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lapef_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
   localparam int SUM_W = PIX_W + 4;

   logic [MODE_W-1:0]  mode_ff;
   logic [CW-1:0]      last_col_ff;
   logic [RW-1:0]      height_ff;
   logic               has_up_ff;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;

   logic [PIX_W-1:0]   cur_mem   [MAX_WIDTH];
   logic [PIX_W-1:0]   above_mem [MAX_WIDTH];
   logic [PIX_W-1:0]   cur_ff, right_ff, above_ff, left_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept, flush_phase, work, produce, wrap, mem_we;
   logic [CW-1:0]      next_col, next_col_p1;
   logic [WIDTH_REG_W-1:0]  wdata_width;
   logic [HEIGHT_REG_W-1:0] wdata_height;
   logic               geom_write;

   logic [PIX_W-1:0]   up_v, left_v, right_v, below_v;
   logic signed [SUM_W-1:0] sum, sum_m;
   logic [PIX_W-1:0]   clamped;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign flush_phase = (row_ff >= height_ff);
   assign work        = accept && (flush_phase || !req_data.flush);
   assign produce     = work && (flush_phase || (row_ff != '0));
   assign mem_we      = work && !flush_phase;
   assign wrap        = (col_ff == last_col_ff);
   assign next_col    = wrap ? '0 : CW'({1'b0, col_ff} + 1'b1);
   assign next_col_p1 = CW'({1'b0, next_col} + 1'b1);

   assign wdata_width  = csr_wdata[WIDTH_REG_W-1:0];
   assign wdata_height = csr_wdata[HEIGHT_REG_W-1:0];
   assign geom_write   = csr_we && ((csr_index == CSR_IMAGE_WIDTH) ||
                                    (csr_index == CSR_IMAGE_HEIGHT));

   always_comb begin
      up_v    = (flush_phase ? has_up_ff : (row_ff > RW'(1))) ? above_ff : '0;
      left_v  = (col_ff != '0) ? left_ff : '0;
      right_v = wrap ? '0 : right_ff;
      below_v = flush_phase ? '0 : req_data.pixel_in;
      sum = $signed({2'b00, cur_ff, 2'b00})
            - $signed(SUM_W'(up_v)) - $signed(SUM_W'(left_v))
            - $signed(SUM_W'(right_v)) - $signed(SUM_W'(below_v));
      sum_m = (mode_ff == MODE_CENTER_NEG) ? -sum : sum;
      if (sum_m < 0) begin
         clamped = '0;
      end else if (sum_m > SUM_W'(PIX_MAX)) begin
         clamped = PIX_W'(PIX_MAX);
      end else begin
         clamped = sum_m[PIX_W-1:0];
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geom_write) begin
         col_in = '0;
         row_in = '0;
      end else if (work) begin
         col_in = next_col;
         if (wrap) begin
            row_in = flush_phase ? '0 : RW'({1'b0, row_ff} + 1'b1);
         end
      end
   end

   always_comb begin
      rsp_data_in.pixel_out = clamped;
      rsp_data_in.row_end   = wrap;
      rsp_data_in.frame_end = flush_phase && wrap;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CENTER_POS;
         last_col_ff  <= CW'(W_RST - 1);
         height_ff    <= RW'(H_RST);
         has_up_ff    <= (H_RST >= 2);
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KERNEL_MODE: begin
                  mode_ff <= csr_wdata[MODE_W-1:0];
               end
               CSR_IMAGE_WIDTH: begin
                  if (wdata_width == '0) begin
                     last_col_ff <= '0;
                  end else if (wdata_width > MAX_WIDTH) begin
                     last_col_ff <= CW'(MAX_WIDTH - 1);
                  end else begin
                     last_col_ff <= CW'(wdata_width - 1'b1);
                  end
               end
               CSR_IMAGE_HEIGHT: begin
                  if (wdata_height == '0) begin
                     height_ff <= RW'(1);
                     has_up_ff <= 1'b0;
                  end else if (wdata_height > MAX_HEIGHT) begin
                     height_ff <= RW'(MAX_HEIGHT);
                     has_up_ff <= (MAX_HEIGHT >= 2);
                  end else begin
                     height_ff <= RW'(wdata_height);
                     has_up_ff <= (wdata_height > 1);
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cur_mem[col_ff]   <= req_data.pixel_in;
         above_mem[col_ff] <= cur_ff;
      end
      if (work) begin
         left_ff  <= cur_ff;
         cur_ff   <= (mem_we && (next_col == col_ff)) ? req_data.pixel_in
                                                      : cur_mem[next_col];
         right_ff <= (mem_we && (next_col_p1 == col_ff)) ? req_data.pixel_in
                                                         : cur_mem[next_col_p1];
         above_ff <= (mem_we && (next_col == col_ff)) ? cur_ff
                                                      : above_mem[next_col];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col_ff)
      else $error("Column counter ran past the last column.");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff)
      else $error("Row counter ran past the flush phase.");

   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.frame_end || rsp_data_ff.row_end))
      else $error("Frame end flagged without row end.");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      produce |=> rsp_valid_ff)
      else $error("A produced result did not reach the result register.");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      (produce && flush_phase && wrap && !geom_write) |=> (row_ff == '0 && col_ff == '0))
      else $error("Counters did not restart after the last flush beat.");

endmodule
